// ===== hdl/sgmu_pkg.sv =====
package sgmu_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned NUM_COMP = 8;

    typedef logic [3:0] t_opcode;

    localparam t_opcode OP_PROJ_PLUS  = 4'd5;
    localparam t_opcode OP_PROJ_MINUS = 4'd6;

    localparam int unsigned NEG_BIT = 3;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] s0_re;
        logic signed [31:0] s0_im;
        logic signed [31:0] s1_re;
        logic signed [31:0] s1_im;
        logic signed [31:0] s2_re;
        logic signed [31:0] s2_im;
        logic signed [31:0] s3_re;
        logic signed [31:0] s3_im;
        logic               last_color;
    } t_sgmu_in;

    typedef struct packed {
        logic signed [31:0] r0_re;
        logic signed [31:0] r0_im;
        logic signed [31:0] r1_re;
        logic signed [31:0] r1_im;
        logic signed [31:0] r2_re;
        logic signed [31:0] r2_im;
        logic signed [31:0] r3_re;
        logic signed [31:0] r3_im;
        logic               last_out;
    } t_sgmu_out;

    // per opcode and result component: source index in bits 2:0, negate in bit 3
    // rows for the projectors are unused
    localparam logic [3:0] PERM_TAB [16][8] = '{
        '{4'd7,  4'd14, 4'd5,  4'd12, 4'd11, 4'd2,  4'd9,  4'd0 },
        '{4'd14, 4'd15, 4'd4,  4'd5,  4'd2,  4'd3,  4'd8,  4'd9 },
        '{4'd5,  4'd12, 4'd15, 4'd6,  4'd9,  4'd0,  4'd3,  4'd10},
        '{4'd0,  4'd1,  4'd2,  4'd3,  4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd4,  4'd5,  4'd6,  4'd7,  4'd0,  4'd1,  4'd2,  4'd3 },
        '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0 },
        '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0 },
        '{4'd9,  4'd0,  4'd3,  4'd10, 4'd13, 4'd4,  4'd7,  4'd14},
        '{4'd11, 4'd2,  4'd9,  4'd0,  4'd15, 4'd6,  4'd13, 4'd4 },
        '{4'd6,  4'd7,  4'd12, 4'd13, 4'd2,  4'd3,  4'd8,  4'd9 },
        '{4'd2,  4'd3,  4'd8,  4'd9,  4'd6,  4'd7,  4'd12, 4'd13},
        '{4'd3,  4'd10, 4'd1,  4'd8,  4'd7,  4'd14, 4'd5,  4'd12},
        '{4'd13, 4'd4,  4'd7,  4'd14, 4'd9,  4'd0,  4'd3,  4'd10},
        '{4'd7,  4'd14, 4'd5,  4'd12, 4'd3,  4'd10, 4'd1,  4'd8 },
        '{4'd14, 4'd15, 4'd4,  4'd5,  4'd10, 4'd11, 4'd0,  4'd1 },
        '{4'd5,  4'd12, 4'd15, 4'd6,  4'd1,  4'd8,  4'd11, 4'd2 }
    };

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        logic signed [31:0] res;
        if (v == 32'sh8000_0000) begin
            res = 32'sh7fff_ffff;
        end else begin
            res = -v;
        end
        return res;
    endfunction

endpackage

// ===== hdl/sgmu_core.sv =====
module sgmu_core (
    input  sgmu_pkg::t_sgmu_in  i_item,
    output sgmu_pkg::t_sgmu_out o_result
);

    logic signed [31:0] s [8];
    logic signed [31:0] r [8];
    logic signed [31:0] perm_r [8];
    logic signed [31:0] proj_r [8];
    logic               proj_sel;
    logic               minus;

    assign s[0] = i_item.s0_re;
    assign s[1] = i_item.s0_im;
    assign s[2] = i_item.s1_re;
    assign s[3] = i_item.s1_im;
    assign s[4] = i_item.s2_re;
    assign s[5] = i_item.s2_im;
    assign s[6] = i_item.s3_re;
    assign s[7] = i_item.s3_im;

    assign minus    = (i_item.opcode == sgmu_pkg::OP_PROJ_MINUS);
    assign proj_sel = (i_item.opcode == sgmu_pkg::OP_PROJ_PLUS) || minus;

    // signed permutation
    always_comb begin
        logic [3:0] e;
        for (int k = 0; k < 8; k++) begin
            e = sgmu_pkg::PERM_TAB[i_item.opcode][k];
            if (e[sgmu_pkg::NEG_BIT]) begin
                perm_r[k] = sgmu_pkg::neg_sat(s[e[2:0]]);
            end else begin
                perm_r[k] = s[e[2:0]];
            end
        end
    end

    // projectors: 33-bit sum or difference, floor halving
    always_comb begin
        logic signed [32:0] sum;
        logic signed [31:0] h;
        for (int k = 0; k < 4; k++) begin
            if (minus) begin
                sum = {s[k][31], s[k]} - {s[k+4][31], s[k+4]};
            end else begin
                sum = {s[k][31], s[k]} + {s[k+4][31], s[k+4]};
            end
            h = sum[32:1];
            proj_r[k]   = h;
            proj_r[k+4] = minus ? sgmu_pkg::neg_sat(h) : h;
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            r[k] = proj_sel ? proj_r[k] : perm_r[k];
        end
    end

    assign o_result.r0_re    = r[0];
    assign o_result.r0_im    = r[1];
    assign o_result.r1_re    = r[2];
    assign o_result.r1_im    = r[3];
    assign o_result.r2_re    = r[4];
    assign o_result.r2_im    = r[5];
    assign o_result.r3_re    = r[6];
    assign o_result.r3_im    = r[7];
    assign o_result.last_out = i_item.last_color;

endmodule

// ===== hdl/spinor_gamma_matrix_unit.sv =====
// spinor gamma matrix unit
// multiplies one colour component of a four-spin complex spinor by the
// Dirac-basis matrix chosen by the opcode (gamma x/y/z/t, gamma5, the two
// chiral projectors, or one of the nine i*sigma products)
// input channel: i_in_valid / o_in_stall carry i_in_data; a beat is taken at
// a rising edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry o_out_data, same rule
// two register stages: the beat is captured in an input register, the
// permute / negate / halve logic sits between it and the result register,
// so a result is offered once the result register has loaded it
// throughput is one beat per cycle while the receiver does not stall; every opcode takes the same path
// when the receiver stalls, the result register holds and the input
// register still takes one beat; only when both are full does o_in_stall rise
// synchronous active-low reset empties both stages; no data is cleared
module spinor_gamma_matrix_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sgmu_pkg::t_sgmu_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sgmu_pkg::t_sgmu_out  o_out_data
);

    logic                r_in_valid;
    sgmu_pkg::t_sgmu_in  r_in_data;
    logic                r_out_valid;
    sgmu_pkg::t_sgmu_out r_out_data;
    sgmu_pkg::t_sgmu_out n_out_data;
    logic                out_load;
    logic                in_load;

    sgmu_core u_core (
        .i_item   (r_in_data),
        .o_result (n_out_data)
    );

    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (out_load && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== tb/sv/tb_spinor_gamma_matrix_unit.sv =====
module tb_spinor_gamma_matrix_unit;

    typedef enum logic [3:0] {
        GAM_X, GAM_Y, GAM_Z, GAM_T, GAM_5, PROJ_PLUS, PROJ_MINUS,
        ISIG_12, ISIG_23, ISIG_24, ISIG_31, ISIG_32, ISIG_34, ISIG_41, ISIG_42, ISIG_43
    } t_gamma_op;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    localparam int RANDOM_HALF = 350;
    localparam int LONG_HOLD   = 400;
    localparam int IDLE_LIMIT  = 2000;

    // component order r0,i0,r1,i1,r2,i2,r3,i3; low 3 bits pick the source, bit 3 negates
    localparam logic [3:0] SPIN_MAP [16][8] = '{
        '{4'd7,  4'd14, 4'd5,  4'd12, 4'd11, 4'd2,  4'd9,  4'd0 },
        '{4'd14, 4'd15, 4'd4,  4'd5,  4'd2,  4'd3,  4'd8,  4'd9 },
        '{4'd5,  4'd12, 4'd15, 4'd6,  4'd9,  4'd0,  4'd3,  4'd10},
        '{4'd0,  4'd1,  4'd2,  4'd3,  4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd4,  4'd5,  4'd6,  4'd7,  4'd0,  4'd1,  4'd2,  4'd3 },
        '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0 },
        '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0 },
        '{4'd9,  4'd0,  4'd3,  4'd10, 4'd13, 4'd4,  4'd7,  4'd14},
        '{4'd11, 4'd2,  4'd9,  4'd0,  4'd15, 4'd6,  4'd13, 4'd4 },
        '{4'd6,  4'd7,  4'd12, 4'd13, 4'd2,  4'd3,  4'd8,  4'd9 },
        '{4'd2,  4'd3,  4'd8,  4'd9,  4'd6,  4'd7,  4'd12, 4'd13},
        '{4'd3,  4'd10, 4'd1,  4'd8,  4'd7,  4'd14, 4'd5,  4'd12},
        '{4'd13, 4'd4,  4'd7,  4'd14, 4'd9,  4'd0,  4'd3,  4'd10},
        '{4'd7,  4'd14, 4'd5,  4'd12, 4'd3,  4'd10, 4'd1,  4'd8 },
        '{4'd14, 4'd15, 4'd4,  4'd5,  4'd10, 4'd11, 4'd0,  4'd1 },
        '{4'd5,  4'd12, 4'd15, 4'd6,  4'd1,  4'd8,  4'd11, 4'd2 }
    };

    localparam logic signed [31:0] XTREME [5] = '{
        32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1, 32'sd1
    };

    localparam string COMP_NAME [8] = '{
        "r0_re", "r0_im", "r1_re", "r1_im", "r2_re", "r2_im", "r3_re", "r3_im"
    };

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic feed_valid = 1'b0;
    logic drain_stall = 1'b0;
    sgmu_pkg::t_sgmu_in feed_beat = '0;
    logic o_in_stall;
    logic o_out_valid;
    sgmu_pkg::t_sgmu_out o_out_data;

    sgmu_pkg::t_sgmu_in  beat_pending_q [$];
    sgmu_pkg::t_sgmu_out spinor_expect_q [$];

    int fail_count = 0;
    int results_seen = 0;

    spinor_gamma_matrix_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (feed_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (feed_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (drain_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] negate_clamped(input logic signed [31:0] v);
        logic signed [31:0] res;
        if (v == 32'sh8000_0000) begin
            res = 32'sh7fff_ffff;
        end else begin
            res = -v;
        end
        return res;
    endfunction

    function automatic sgmu_pkg::t_sgmu_out gamma_apply(input sgmu_pkg::t_sgmu_in beat);
        logic signed [31:0] src [8];
        logic signed [31:0] res [8];
        logic [32:0] wide;
        logic signed [31:0] half;
        logic [3:0] code;
        logic minus;
        sgmu_pkg::t_sgmu_out r;
        src = '{beat.s0_re, beat.s0_im, beat.s1_re, beat.s1_im,
                beat.s2_re, beat.s2_im, beat.s3_re, beat.s3_im};
        if (beat.opcode == PROJ_PLUS || beat.opcode == PROJ_MINUS) begin
            minus = (beat.opcode == PROJ_MINUS);
            // upper spin pair against lower spin pair, 33-bit sum or difference then floor halving
            for (int k = 0; k < 4; k++) begin
                if (minus) begin
                    wide = {src[k][31], src[k]} - {src[k+4][31], src[k+4]};
                end else begin
                    wide = {src[k][31], src[k]} + {src[k+4][31], src[k+4]};
                end
                half = wide[32:1];
                res[k] = half;
                res[k+4] = minus ? negate_clamped(half) : half;
            end
        end else begin
            for (int k = 0; k < 8; k++) begin
                code = SPIN_MAP[beat.opcode][k];
                res[k] = code[3] ? negate_clamped(src[code[2:0]]) : src[code[2:0]];
            end
        end
        r.r0_re = res[0];
        r.r0_im = res[1];
        r.r1_re = res[2];
        r.r1_im = res[3];
        r.r2_re = res[4];
        r.r2_im = res[5];
        r.r3_re = res[6];
        r.r3_im = res[7];
        r.last_out = beat.last_color;
        return r;
    endfunction

    function automatic logic signed [31:0] out_comp(input sgmu_pkg::t_sgmu_out r, input int k);
        logic signed [31:0] v;
        case (k)
            0: v = r.r0_re;
            1: v = r.r0_im;
            2: v = r.r1_re;
            3: v = r.r1_im;
            4: v = r.r2_re;
            5: v = r.r2_im;
            6: v = r.r3_re;
            default: v = r.r3_im;
        endcase
        return v;
    endfunction

    task automatic queue_beat(input t_gamma_op op, input logic signed [31:0] v [8],
                              input logic last);
        sgmu_pkg::t_sgmu_in beat;
        beat.opcode = op;
        beat.s0_re = v[0];
        beat.s0_im = v[1];
        beat.s1_re = v[2];
        beat.s1_im = v[3];
        beat.s2_re = v[4];
        beat.s2_im = v[5];
        beat.s3_re = v[6];
        beat.s3_im = v[7];
        beat.last_color = last;
        beat_pending_q.push_back(beat);
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        if ($urandom_range(0, 7) == 0) begin
            v = XTREME[$urandom_range(0, 4)];
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    task automatic wait_all_done();
        while (beat_pending_q.size() != 0 || spinor_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic queue_random(input int count);
        logic signed [31:0] v [8];
        logic last;
        for (int n = 0; n < count; n++) begin
            for (int j = 0; j < 8; j++) begin
                v[j] = pick_value();
            end
            // three colours per site, with an occasional stray marker
            last = (n % 3 == 2);
            if ($urandom_range(0, 15) == 0) begin
                last = ~last;
            end
            queue_beat(t_gamma_op'($urandom_range(0, 15)), v, last);
        end
    endtask

    // stimulus
    initial begin
        logic signed [31:0] v [8];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every opcode with the extremes rotated through the components
        for (int op = 0; op < 16; op++) begin
            for (int j = 0; j < 8; j++) begin
                v[j] = XTREME[(j + op) % 5];
            end
            queue_beat(t_gamma_op'(op), v, op[0]);
        end
        v = '{8{32'sh8000_0000}};
        queue_beat(GAM_X, v, 1'b1);
        queue_beat(PROJ_PLUS, v, 1'b0);
        v = '{8{32'sh7fff_ffff}};
        queue_beat(PROJ_PLUS, v, 1'b1);
        // difference of min and max halves to min, whose negation clamps
        v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
        queue_beat(PROJ_MINUS, v, 1'b0);
        v = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        queue_beat(PROJ_MINUS, v, 1'b1);
        // odd negative sums round toward minus infinity
        v = '{-32'sd1, 32'sd1, 32'sd0, -32'sd3, 32'sd0, 32'sd0, 32'sd1, 32'sd0};
        queue_beat(PROJ_MINUS, v, 1'b0);
        queue_beat(PROJ_PLUS, v, 1'b1);
        wait_all_done();

        queue_random(RANDOM_HALF);
        wait_all_done();
        queue_random(RANDOM_HALF);
        wait_all_done();

        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        logic nxt_valid;
        nxt_valid = 1'b0;
        if (!i_rst_n) begin
            feed_valid <= 1'b0;
        end else begin
            if (feed_valid && !o_in_stall) begin
                spinor_expect_q.push_back(gamma_apply(beat_pending_q[0]));
                void'(beat_pending_q.pop_front());
            end
            if (feed_valid && o_in_stall) begin
                nxt_valid = 1'b1;
            end else if (gap_left != 0) begin
                gap_left--;
            end else if (beat_pending_q.size() != 0) begin
                nxt_valid = 1'b1;
                feed_beat <= beat_pending_q[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
            feed_valid <= nxt_valid;
        end
    end

    // receiver: checks each result beat and stalls on its own pattern
    int hold_left = 0;
    logic hold_done = 1'b0;
    int mode_left = 0;
    t_rx_mode rx_mode = RX_FREE;

    always @(posedge i_clk) begin
        logic nxt_stall;
        sgmu_pkg::t_sgmu_out want;
        nxt_stall = 1'b0;
        if (!i_rst_n) begin
            drain_stall <= 1'b0;
        end else begin
            if (o_out_valid && !drain_stall) begin
                results_seen++;
                if (spinor_expect_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    want = spinor_expect_q.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (out_comp(o_out_data, k) !== out_comp(want, k)) begin
                            $error("%s: expected %0d, got %0d", COMP_NAME[k],
                                   out_comp(want, k), out_comp(o_out_data, k));
                            fail_count++;
                        end
                    end
                    if (o_out_data.last_out !== want.last_out) begin
                        $error("last_out: expected %0d, got %0d", want.last_out,
                               o_out_data.last_out);
                        fail_count++;
                    end
                end
            end
            // one long hold so the block backs up and stalls its input
            if (hold_left != 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (!hold_done && results_seen >= 150) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                nxt_stall = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   nxt_stall = 1'b0;
                    RX_LIGHT:  nxt_stall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  nxt_stall = ($urandom_range(0, 3) != 0);
                    RX_TOGGLE: nxt_stall = ~drain_stall;
                    default:   nxt_stall = 1'b0;
                endcase
            end
            drain_stall <= nxt_stall;
        end
    end

    // watchdog on cycles where neither side moves a beat
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (feed_valid && !o_in_stall) || (o_out_valid && !drain_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

// ===== spinor_gamma_matrix_unit.f =====
hdl/sgmu_pkg.sv
hdl/sgmu_core.sv
hdl/spinor_gamma_matrix_unit.sv
tb/sv/tb_spinor_gamma_matrix_unit.sv
